### src/gtd_pkg.sv
package gtd_pkg;

    // History depth per pad and the address width it needs.
    localparam int unsigned HIST_DEPTH = 16;
    localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
    localparam int unsigned PAD_COUNT  = 2;
    localparam int unsigned RAM_DEPTH  = HIST_DEPTH * PAD_COUNT;
    localparam int unsigned FILL_W     = $clog2(HIST_DEPTH + 1);

    // Stick and button constants.
    localparam logic [7:0]  DEF_DZ      = 8'h30;
    localparam logic [7:0]  CENTER      = 8'h80;
    localparam logic [7:0]  BAND_LO     = CENTER - DEF_DZ;
    localparam logic [7:0]  BAND_HI     = CENTER + DEF_DZ;
    localparam logic [31:0] DPAD_MASK   = 32'h0000_F000;
    localparam logic [31:0] DPAD_LEFT   = 32'h0000_8000;
    localparam logic [31:0] DPAD_RIGHT  = 32'h0000_2000;
    localparam logic [31:0] DPAD_UP     = 32'h0000_1000;
    localparam logic [31:0] DPAD_DOWN   = 32'h0000_4000;
    localparam logic [31:0] OUT_KEEP    = 32'h00FF_FFFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEADZONE     = 2'd0;
    localparam logic [1:0] CFG_TURBO_ENABLE = 2'd1;
    localparam logic [1:0] CFG_TURBO_MASK   = 2'd2;
    localparam logic [1:0] CFG_FRAMES_ON    = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } t_state;

    // Pull an axis value inside the configured band but outside the default band to just inside the default band.
    function automatic logic [7:0] remap_axis(input logic [7:0] v, input logic [7:0] dz);
        logic [8:0] sum;
        logic [8:0] hi_lim;
        logic [7:0] res;
        sum    = {1'b0, v} + {1'b0, dz};
        hi_lim = {1'b0, CENTER} + {1'b0, dz};
        res    = v;
        if (dz != DEF_DZ) begin
            if ((v < BAND_LO) && (sum >= {1'b0, CENTER})) begin
                res = BAND_LO + 8'd1;
            end else if ((v > BAND_HI) && ({1'b0, v} <= hi_lim)) begin
                res = BAND_HI - 8'd1;
            end
        end
        return res;
    endfunction

endpackage

### src/gtd_ram.sv
module gtd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/gamepad_turbo_deadzone.sv
// Channel   Direction  Handshake                          Payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tdata buttons,x,y; tuser pad
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata buttons,x,y
// cfg       in         i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// With turbo on, each accepted frame reads the pad's history (0 to 16 words) one read a
// cycle on the single read port of the history RAM, waits for the last read word and
// then loads the result; no new frame is accepted until the sequencer is idle again.
// With turbo off the result is loaded without history reads. Reset is synchronous and
// clears the sequencer and the history counts and pointers, and sets the configuration
// registers to their defaults. A stalled result is held in the output register while
// the next frame is read.
module gamepad_turbo_deadzone
    import gtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // buttons_in[31:0], stick_x_in[39:32], stick_y_in[47:40]
    input  logic        i_s_axis_tuser,  // pad_select
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // buttons_out[31:0], stick_x_out[39:32], stick_y_out[47:40]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Configuration registers.
    logic [7:0]  r_deadzone;
    logic        r_turbo_enable;
    logic [31:0] r_turbo_mask;
    logic [4:0]  r_frames_on;

    // Sequencer and per-pad history bookkeeping.
    t_state            r_state, n_state;
    logic [FILL_W-1:0] r_fill [PAD_COUNT];
    logic [HIST_AW-1:0] r_head [PAD_COUNT];
    logic [FILL_W-1:0] r_cnt, n_cnt;
    logic              r_rd_pend;
    logic [31:0]       r_seen, n_seen;

    // Latched request.
    logic        r_pad;
    logic [31:0] r_buttons;
    logic [7:0]  r_x;
    logic [7:0]  r_y;

    // Output register.
    logic        r_out_valid;
    logic [47:0] r_out_data;

    // RAM interface.
    logic                     ram_re;
    logic [HIST_AW:0]         ram_raddr;
    logic [31:0]              ram_rdata;
    logic                     ram_we;
    logic [HIST_AW:0]         ram_waddr;

    logic              in_accept;
    logic              out_free;
    logic              done_fire;
    logic [FILL_W-1:0] fill_cur;
    logic [HIST_AW-1:0] head_cur;
    logic [HIST_AW-1:0] head_next;
    logic [FILL_W-1:0] window;
    logic [FILL_W-1:0] win_m1;
    logic [FILL_W-1:0] fill_new;
    logic [8:0]        x_dz, y_dz, hi_lim;
    logic [31:0]       drop;
    logic [31:0]       mask;
    logic [31:0]       fin;
    logic [31:0]       result;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign done_fire       = (r_state == ST_DONE) && out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign fill_cur  = r_fill[r_pad];
    assign head_cur  = r_head[r_pad];
    assign head_next = head_cur + 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone     <= DEF_DZ;
            r_turbo_enable <= 1'b0;
            r_turbo_mask   <= 32'h0000_00F0;
            r_frames_on    <= 5'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEADZONE:     r_deadzone     <= i_cfg_data[7:0];
                CFG_TURBO_ENABLE: r_turbo_enable <= i_cfg_data[0];
                CFG_TURBO_MASK:   r_turbo_mask   <= i_cfg_data;
                CFG_FRAMES_ON:    r_frames_on    <= i_cfg_data[4:0];
                default:          r_deadzone     <= r_deadzone;
            endcase
        end
    end

    // Turbo mask, with D-pad directions dropped where the raw stick is past the deadzone, and the button result.
    always_comb begin
        x_dz   = {1'b0, r_x} + {1'b0, r_deadzone};
        y_dz   = {1'b0, r_y} + {1'b0, r_deadzone};
        hi_lim = {1'b0, CENTER} + {1'b0, r_deadzone};
        drop   = '0;
        if (x_dz < {1'b0, CENTER}) drop = drop | DPAD_LEFT;
        if ({1'b0, r_x} > hi_lim)  drop = drop | DPAD_RIGHT;
        if (y_dz < {1'b0, CENTER}) drop = drop | DPAD_UP;
        if ({1'b0, r_y} > hi_lim)  drop = drop | DPAD_DOWN;
        mask = r_turbo_mask;
        if ((r_turbo_mask & DPAD_MASK) != '0) begin
            mask = r_turbo_mask & ~drop;
        end
        fin    = (r_buttons & ~mask) | (r_buttons & mask & ~r_seen);
        result = r_turbo_enable ? (fin & OUT_KEEP) : r_buttons;
    end

    // New history count: window clamped to 1..HIST_DEPTH, oldest entries dropped.
    always_comb begin
        if (r_frames_on == '0) begin
            window = FILL_W'(1);
        end else if (FILL_W'(r_frames_on) > FILL_W'(HIST_DEPTH)) begin
            window = FILL_W'(HIST_DEPTH);
        end else begin
            window = FILL_W'(r_frames_on);
        end
        win_m1   = window - 1'b1;
        fill_new = ((fill_cur > win_m1) ? win_m1 : fill_cur) + 1'b1;
    end

    // History reads walk back from the newest entry of the pad.
    assign ram_re    = (r_state == ST_READ) && (r_cnt != fill_cur);
    assign ram_raddr = {r_pad, head_cur - r_cnt[HIST_AW-1:0]};
    assign ram_we    = done_fire && r_turbo_enable;
    assign ram_waddr = {r_pad, head_next};

    gtd_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (fin),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state, read counter and history AND.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_seen  = r_seen;
        if (r_rd_pend) begin
            n_seen = r_seen & ram_rdata;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_cnt   = '0;
                    n_seen  = '1;
                    n_state = r_turbo_enable ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                if (ram_re) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!r_rd_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int p = 0; p < PAD_COUNT; p++) begin
                r_fill[p] <= '0;
                r_head[p] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_pend <= ram_re;
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_fill[r_pad] <= fill_new;
                r_head[r_pad] <= head_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_seen <= n_seen;
        if (in_accept) begin
            r_pad     <= i_s_axis_tuser;
            r_buttons <= i_s_axis_tdata[31:0];
            r_x       <= i_s_axis_tdata[39:32];
            r_y       <= i_s_axis_tdata[47:40];
        end
        if (done_fire) begin
            r_out_data <= {remap_axis(r_y, r_deadzone), remap_axis(r_x, r_deadzone), result};
        end
    end

    // History counts never exceed the depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill[0] <= FILL_W'(HIST_DEPTH)) && (r_fill[1] <= FILL_W'(HIST_DEPTH)))
        else $error("history count above depth");

    // The read walk never passes the pad's history count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_cnt <= fill_cur))
        else $error("history read past fill");

    // An accepted request deasserts the ready in the cycle after it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_s_axis_tready)
        else $error("request accepted while busy");

    // A history write always comes with a result in the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> o_m_axis_tvalid)
        else $error("history written without a result");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import gtd_pkg::*;

    localparam int CTR = int'(CENTER);
    localparam int DZ0 = int'(DEF_DZ);
    localparam int RANDOM_FRAMES = 1500;

    typedef struct packed {
        logic [7:0]  sy;
        logic [7:0]  sx;
        logic [31:0] btn;
    } t_frame_result;

    typedef enum logic {
        RK_FRAME,
        RK_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind     kind;
        logic [1:0]    idx;
        logic [31:0]   data;
        logic          pad;
        logic [31:0]   btn;
        logic [7:0]    sx;
        logic [7:0]    sy;
        bit            typed;
        t_frame_result want;
    } t_stim_row;

    // Clock, reset and every block input start at known values.
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_DEADZONE;
    logic [31:0] cfg_data  = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;
    logic        o_cfg_ready;

    // Shadow copy of the block state and registers used for prediction.
    logic [31:0] hist_words [2][HIST_DEPTH];
    int          hist_count [2];
    logic [7:0]  cfg_dz;
    logic        cfg_turbo;
    logic [31:0] cfg_mask;
    logic [4:0]  cfg_window;

    t_frame_result pending_frames[$];
    t_stim_row     directed_rows[$];
    logic [31:0]   held_btn [2];
    int            err_count   = 0;
    int            burst_left  = 0;
    int            frames_sent = 0;
    int            rx_left     = 0;
    int            rx_mode     = 0;

    gamepad_turbo_deadzone dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // An axis value inside the configured band but outside the default band is
    // pulled to just inside the default band. Bounds are plain integers.
    function automatic logic [7:0] pull_axis(input logic [7:0] v, input int dz);
        int a;
        a = int'(v);
        if (dz != DZ0) begin
            if (a < CTR - DZ0 && a >= CTR - dz) begin
                return 8'(CTR - DZ0 + 1);
            end
            if (a > CTR + DZ0 && a <= CTR + dz) begin
                return 8'(CTR + DZ0 - 1);
            end
        end
        return v;
    endfunction

    // Work out one frame's result and advance the per-pad history.
    function automatic t_frame_result predict_frame(input logic pad, input logic [31:0] btn,
                                                     input logic [7:0] sx, input logic [7:0] sy);
        t_frame_result res;
        logic [31:0]   mask;
        logic [31:0]   drop;
        logic [31:0]   seen;
        logic [31:0]   fin;
        int            dz;
        int            fill;
        int            win;
        dz      = int'(cfg_dz);
        res.btn = btn;
        res.sx  = pull_axis(sx, dz);
        res.sy  = pull_axis(sy, dz);
        if (cfg_turbo) begin
            mask = cfg_mask;
            // A stick pushed past the deadzone keeps its D-pad direction out of turbo.
            if ((mask & DPAD_MASK) != 0) begin
                drop = '0;
                if (int'(sx) < CTR - dz) drop |= DPAD_LEFT;
                if (int'(sx) > CTR + dz) drop |= DPAD_RIGHT;
                if (int'(sy) < CTR - dz) drop |= DPAD_UP;
                if (int'(sy) > CTR + dz) drop |= DPAD_DOWN;
                mask &= ~drop;
            end
            fill = hist_count[pad];
            if (fill > int'(HIST_DEPTH)) fill = int'(HIST_DEPTH);
            seen = '1;
            for (int i = 0; i < fill; i++) begin
                seen &= hist_words[pad][i];
            end
            fin = (btn & ~mask) | (btn & mask & ~seen);
            // Clamp the window, trim the oldest entries and push the new word.
            win = int'(cfg_window);
            if (win < 1) win = 1;
            if (win > int'(HIST_DEPTH)) win = int'(HIST_DEPTH);
            if (fill > win - 1) fill = win - 1;
            for (int i = fill; i > 0; i--) begin
                hist_words[pad][i] = hist_words[pad][i - 1];
            end
            hist_words[pad][0] = fin;
            hist_count[pad]    = fill + 1;
            res.btn = fin & OUT_KEEP;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s mismatch: got 0x%0h, expected 0x%0h",
                                      name, got, want));
        end
    endtask

    // Receiver stall pattern: long stretches of one mode, then a new mode.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(50, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_tready <= ($urandom_range(0, 2) == 0);
            end
        endcase
    end

    // Compare every accepted result with the oldest pending expectation.
    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got = o_m_axis_tdata;
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("unexpected result 0x%0h", got));
            end else begin
                want = pending_frames.pop_front();
                check_field("buttons_out", got.btn, want.btn);
                check_field("stick_x_out", 32'(got.sx), 32'(want.sx));
                check_field("stick_y_out", 32'(got.sy), 32'(want.sy));
            end
        end
    end

    // Send one frame request, in bursts with random gaps between them.
    task automatic send_frame(input logic pad, input logic [31:0] btn, input logic [7:0] sx,
                              input logic [7:0] sy, input bit use_typed,
                              input t_frame_result typed_res);
        int            gap;
        t_frame_result pred;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {sy, sx, btn};
        s_tuser  <= pad;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = predict_frame(pad, btn, sx, sy);
        pending_frames.insert(pending_frames.size(), use_typed ? typed_res : pred);
        held_btn[pad] = btn;
        frames_sent++;
    endtask

    // Let every pending result drain, then write one register.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEADZONE:     cfg_dz     = data[7:0];
            CFG_TURBO_ENABLE: cfg_turbo  = data[0];
            CFG_TURBO_MASK:   cfg_mask   = data;
            CFG_FRAMES_ON:    cfg_window = data[4:0];
            default: ;
        endcase
    endtask

    function automatic void row_cfg(input logic [1:0] idx, input logic [31:0] data);
        t_stim_row r;
        r      = '{kind: RK_CFG, default: '0};
        r.idx  = idx;
        r.data = data;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void row_frame(input logic pad, input logic [31:0] btn,
                                      input logic [7:0] sx, input logic [7:0] sy,
                                      input bit typed, input logic [31:0] wb,
                                      input logic [7:0] wx, input logic [7:0] wy);
        t_stim_row r;
        r       = '{kind: RK_FRAME, default: '0};
        r.pad   = pad;
        r.btn   = btn;
        r.sx    = sx;
        r.sy    = sy;
        r.typed = typed;
        r.want  = '{sy: wy, sx: wx, btn: wb};
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Axis values cluster around the band edges of the current deadzone.
    function automatic logic [7:0] pick_axis();
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 255);
            1: v = CTR;
            2: v = CTR - int'(cfg_dz) + int'($urandom_range(0, 2)) - 1;
            3: v = CTR + int'(cfg_dz) + int'($urandom_range(0, 2)) - 1;
            4: v = ($urandom_range(0, 1) ? CTR + DZ0 : CTR - DZ0)
                   + int'($urandom_range(0, 2)) - 1;
            default: v = $urandom_range(0, 1) ? 255 : 0;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // Directed rows, random phases of configuration and frames, then the drain.
    initial begin
        logic        pad;
        logic [31:0] btn;
        int          n;
        t_frame_result none;
        none = '0;
        cfg_dz     = DEF_DZ;
        cfg_turbo  = 1'b0;
        cfg_mask   = 32'h0000_00F0;
        cfg_window = 5'd2;
        for (int p = 0; p < 2; p++) begin
            hist_count[p] = 0;
            held_btn[p]   = '0;
        end

        // Turbo off, default deadzone, then remap bands at several deadzones.
        row_frame(1'b0, 32'h0000_0000, 8'h00, 8'h00, 1, 32'h0000_0000, 8'h00, 8'h00);
        row_frame(1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        row_frame(1'b0, 32'hA5A5_A5A5, 8'h80, 8'h80, 1, 32'hA5A5_A5A5, 8'h80, 8'h80);
        row_cfg(CFG_DEADZONE, 32'h50);
        row_frame(1'b0, 32'h1234_5678, 8'h30, 8'hD0, 1, 32'h1234_5678, 8'h51, 8'hAF);
        row_frame(1'b1, 32'h8765_4321, 8'h2F, 8'hD1, 1, 32'h8765_4321, 8'h2F, 8'hD1);
        row_frame(1'b0, 32'h0000_0001, 8'h4F, 8'hB1, 1, 32'h0000_0001, 8'h51, 8'hAF);
        row_frame(1'b1, 32'h8000_0000, 8'h50, 8'hB0, 1, 32'h8000_0000, 8'h50, 8'hB0);
        row_cfg(CFG_DEADZONE, 32'hFF);
        row_frame(1'b0, 32'h5A5A_5A5A, 8'h00, 8'hFF, 1, 32'h5A5A_5A5A, 8'h51, 8'hAF);
        row_cfg(CFG_DEADZONE, 32'h10);
        row_frame(1'b1, 32'h0F0F_0F0F, 8'h40, 8'hC0, 1, 32'h0F0F_0F0F, 8'h40, 8'hC0);

        // Turbo on with every button masked: an empty history blocks them all.
        row_cfg(CFG_DEADZONE, 32'h30);
        row_cfg(CFG_TURBO_MASK, 32'hFFFF_FFFF);
        row_cfg(CFG_FRAMES_ON, 32'd2);
        row_cfg(CFG_TURBO_ENABLE, 32'd1);
        row_frame(1'b0, 32'hFFFF_FFFF, 8'h80, 8'h80, 1, 32'h0000_0000, 8'h80, 8'h80);
        row_frame(1'b0, 32'hFFFF_FFFF, 8'h80, 8'h80, 1, 32'h00FF_FFFF, 8'h80, 8'h80);
        row_frame(1'b0, 32'hFFFF_FFFF, 8'h80, 8'h80, 0, '0, '0, '0);
        row_frame(1'b0, 32'hFFFF_FFFF, 8'h80, 8'h80, 0, '0, '0, '0);
        row_frame(1'b1, 32'h0000_F0F0, 8'h00, 8'h00, 0, '0, '0, '0);
        row_frame(1'b1, 32'h0000_F0F0, 8'hFF, 8'hFF, 0, '0, '0, '0);

        // Window of zero, then a window longer than the history.
        row_cfg(CFG_FRAMES_ON, 32'd0);
        row_frame(1'b0, 32'hFFFF_FFFF, 8'h80, 8'h80, 0, '0, '0, '0);
        row_frame(1'b0, 32'hFFFF_FFFF, 8'h80, 8'h80, 0, '0, '0, '0);
        row_cfg(CFG_FRAMES_ON, 32'd31);
        row_frame(1'b1, 32'hFFFF_FFFF, 8'h7F, 8'h81, 0, '0, '0, '0);
        row_frame(1'b1, 32'h0000_0000, 8'h80, 8'h80, 0, '0, '0, '0);
        row_frame(1'b1, 32'hFFFF_FFFF, 8'h80, 8'h80, 0, '0, '0, '0);

        // D-pad only mask at a deadzone of 0x80.
        row_cfg(CFG_TURBO_MASK, 32'h0000_F000);
        row_cfg(CFG_DEADZONE, 32'h80);
        row_frame(1'b0, 32'hFFFF_FFFF, 8'h00, 8'hFF, 0, '0, '0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == RK_CFG) begin
                write_reg(directed_rows[k].idx, directed_rows[k].data);
            end else begin
                send_frame(directed_rows[k].pad, directed_rows[k].btn, directed_rows[k].sx,
                           directed_rows[k].sy, directed_rows[k].typed,
                           directed_rows[k].want);
            end
        end

        frames_sent = 0;
        while (frames_sent < RANDOM_FRAMES) begin
            // New settings for this phase; the history carries over.
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0: write_reg(CFG_DEADZONE, 32'd0);
                    1: write_reg(CFG_DEADZONE, 32'd255);
                    2: write_reg(CFG_DEADZONE, 32'd48);
                    3: write_reg(CFG_DEADZONE, 32'd128);
                    4: write_reg(CFG_DEADZONE, 32'($urandom_range(0, 255)));
                    default: write_reg(CFG_DEADZONE, 32'($urandom_range(48, 128)));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_TURBO_MASK, 32'h0000_0000);
                    1: write_reg(CFG_TURBO_MASK, 32'hFFFF_FFFF);
                    2: write_reg(CFG_TURBO_MASK, 32'h0000_F000);
                    3: write_reg(CFG_TURBO_MASK, 32'h0000_00F0);
                    default: write_reg(CFG_TURBO_MASK, $urandom);
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 7))
                    0: write_reg(CFG_FRAMES_ON, 32'd0);
                    1: write_reg(CFG_FRAMES_ON, 32'd31);
                    2: write_reg(CFG_FRAMES_ON, 32'd16);
                    3: write_reg(CFG_FRAMES_ON, 32'd1);
                    4: write_reg(CFG_FRAMES_ON, 32'($urandom_range(0, 31)));
                    default: write_reg(CFG_FRAMES_ON, 32'($urandom_range(1, 16)));
                endcase
            end
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_TURBO_ENABLE, 32'($urandom_range(0, 3) != 0));
            end

            // Mostly held buttons per pad, so turbo toggling runs through full windows.
            n = $urandom_range(20, 120);
            for (int k = 0; k < n; k++) begin
                pad = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: btn = held_btn[pad];
                    5: btn = held_btn[pad] ^ (32'h1 << $urandom_range(0, 31));
                    6, 7, 8: btn = $urandom;
                    default: btn = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                endcase
                send_frame(pad, btn, pick_axis(), pick_axis(), 0, none);
            end
        end

        // Drain, then give the block time to show any stray result.
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop for a hung handshake.
    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
